/* rtl/core/wnnd_pkg.sv */
package wnnd_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int MAX_RANK_DEF = 8;
	localparam int COORD_INT_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF = 8;

	localparam int OUT_BITS = 27;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int CNT_CFG_BITS = 9;
	localparam int RANK_CFG_BITS = 3;
	localparam int MUL_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RANK = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MUL_FACTOR = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Controller to datapath.
	typedef struct packed {
		logic load_wr;   // write the input beat into the point table
		logic q_start;   // capture the query position, clear the nearest list
		logic rd_en;     // read the next point of the table
		logic acc_en;    // a point read last cycle enters the distance pipe
		logic sq_start;  // begin the square root of the chosen entry
		logic sq_step;   // one square root iteration
		logic mul_en;    // scale the root and load the output register
	} wnnd_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic rd_last;   // the read issued this cycle is the last one
		logic pipe_idle; // no distance in flight
		logic sq_done;   // square root finished
		logic out_full;  // output register holds a beat
	} wnnd_sts_t;

endpackage

/* rtl/core/worley_nth_nearest_distance.sv */
// Nth-nearest feature point distance for cellular noise.
// Input stream s_axis: one beat is either a load (tuser = 0), which writes a
// feature point into slot point_index, or a query (tuser = 1), which gives a
// sample position. A load gives no output beat.
// A query reads N points, one per cycle from the point table, where N is
// point_count clamped to the table size and never less than one read. They go
// through a three-stage distance pipeline into a sorted list of the smallest
// squared distances. The rank-th entry then goes through a bit-serial square
// root, one root bit per cycle, and is scaled by mul_factor.
// At the default widths a query passes through N reads, the pipeline drain,
// 19 root steps and one scaling step before its result beat is valid; the
// input is ready again only once the controller is back in idle, so the block
// takes no new beat while a query is in progress. The result beat sits in an
// output register; if the receiver stalls, the block holds the finished result
// and accepts the next beat, but a following query waits before scaling until
// the register is free. Reset clears the registers to point_count 1, rank 0,
// mul_factor 256; the table content is undefined until loaded.
module worley_nth_nearest_distance #(
	parameter int MAX_POINTS = wnnd_pkg::MAX_POINTS_DEF,
	parameter int MAX_RANK = wnnd_pkg::MAX_RANK_DEF,
	parameter int COORD_INT_BITS = wnnd_pkg::COORD_INT_BITS_DEF,
	parameter int FRAC_BITS = wnnd_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// point_index, coord_x, coord_y, coord_z, zero fill
	input  logic [((8 + 3*(COORD_INT_BITS+FRAC_BITS)) + 7) / 8 * 8 - 1:0] s_axis_tdata,
	// req_type
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// scaled_distance, zero fill
	output logic [31:0] m_axis_tdata,
	// rank_error
	output logic m_axis_tuser,
	input  logic cfg_we,
	input  logic [wnnd_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [wnnd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	localparam int CB = COORD_INT_BITS + FRAC_BITS;

	logic [wnnd_pkg::CNT_CFG_BITS-1:0] point_count_q;
	logic [wnnd_pkg::RANK_CFG_BITS-1:0] rank_q;
	logic [wnnd_pkg::MUL_BITS-1:0] mul_factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= wnnd_pkg::CNT_CFG_BITS'(1);
			rank_q <= '0;
			mul_factor_q <= wnnd_pkg::MUL_BITS'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				wnnd_pkg::REG_POINT_COUNT:
					point_count_q <= cfg_data[wnnd_pkg::CNT_CFG_BITS-1:0];
				wnnd_pkg::REG_RANK: rank_q <= cfg_data[wnnd_pkg::RANK_CFG_BITS-1:0];
				wnnd_pkg::REG_MUL_FACTOR: mul_factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wnnd_pkg::wnnd_cmd_t cmd;
	wnnd_pkg::wnnd_sts_t sts;
	logic in_beat;
	logic [wnnd_pkg::OUT_BITS-1:0] scaled_distance;

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = sts.out_full;
	assign m_axis_tdata = {5'b0, scaled_distance};

	wnnd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_beat(in_beat),
		.req_type(s_axis_tuser),
		.in_ready(s_axis_tready),
		.cmd(cmd),
		.sts(sts)
	);

	wnnd_datapath #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_RANK(MAX_RANK),
		.COORD_INT_BITS(COORD_INT_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.point_index(s_axis_tdata[7:0]),
		.coord_x(s_axis_tdata[8 +: CB]),
		.coord_y(s_axis_tdata[8 + CB +: CB]),
		.coord_z(s_axis_tdata[8 + 2*CB +: CB]),
		.point_count(point_count_q),
		.rank(rank_q),
		.mul_factor(mul_factor_q),
		.scaled_distance(scaled_distance),
		.rank_error(m_axis_tuser),
		.out_take(m_axis_tvalid && m_axis_tready)
	);

endmodule

/* rtl/core/wnnd_datapath.sv */
module wnnd_datapath #(
	parameter int MAX_POINTS = wnnd_pkg::MAX_POINTS_DEF,
	parameter int MAX_RANK = wnnd_pkg::MAX_RANK_DEF,
	parameter int COORD_INT_BITS = wnnd_pkg::COORD_INT_BITS_DEF,
	parameter int FRAC_BITS = wnnd_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  wnnd_pkg::wnnd_cmd_t cmd,
	output wnnd_pkg::wnnd_sts_t sts,
	input  logic [7:0] point_index,
	input  logic [COORD_INT_BITS+FRAC_BITS-1:0] coord_x,
	input  logic [COORD_INT_BITS+FRAC_BITS-1:0] coord_y,
	input  logic [COORD_INT_BITS+FRAC_BITS-1:0] coord_z,
	input  logic [wnnd_pkg::CNT_CFG_BITS-1:0] point_count,
	input  logic [wnnd_pkg::RANK_CFG_BITS-1:0] rank,
	input  logic [wnnd_pkg::MUL_BITS-1:0] mul_factor,
	output logic [wnnd_pkg::OUT_BITS-1:0] scaled_distance,
	output logic rank_error,
	input  logic out_take
);
	localparam int CB = COORD_INT_BITS + FRAC_BITS;
	localparam int D2B = 2 * CB + 2;
	localparam int RB = D2B / 2 + 1;
	localparam int AB = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = (8 > AB) ? 8 : AB;
	localparam int RKB = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int KW = $clog2(MAX_RANK + 1);
	localparam int PW = RB + wnnd_pkg::MUL_BITS;
	localparam int SQI = (RB > 1) ? $clog2(RB + 1) : 1;
	localparam int EW = (wnnd_pkg::CNT_CFG_BITS > CW) ? wnnd_pkg::CNT_CFG_BITS : CW;

	logic [3*CB-1:0] mem [MAX_POINTS];
	logic [3*CB-1:0] rd_s1;
	logic [CB-1:0] qx_q, qy_q, qz_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] count_c;
	logic [EW-1:0] pc_ext;
	logic [IW-1:0] idx_ext;

	// Clamp the point count.
	always_comb begin
		pc_ext = EW'(point_count);
		if (pc_ext > EW'(MAX_POINTS))
			count_c = CW'(MAX_POINTS);
		else
			count_c = CW'(pc_ext);
		idx_ext = IW'(point_index);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && {1'b0, idx_ext} < (IW+1)'(MAX_POINTS))
			mem[idx_ext[AB-1:0]] <= {coord_z, coord_y, coord_x};
		if (cmd.rd_en)
			rd_s1 <= mem[rd_ptr_q[AB-1:0]];
		if (cmd.q_start) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
			qz_q <= coord_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_ptr_q <= '0;
		else if (cmd.q_start)
			rd_ptr_q <= '0;
		else if (cmd.rd_en)
			rd_ptr_q <= rd_ptr_q + 1'b1;
	end

	assign sts.rd_last = (rd_ptr_q + 1'b1) >= count_c;

	// Stage 2: absolute differences. Stage 3: squares. Stage 4: sum.
	logic v_s2, v_s3, v_s4;
	logic [CB-1:0] dx_s2, dy_s2, dz_s2;
	logic [2*CB-1:0] sx_s3, sy_s3, sz_s3;
	logic [D2B-1:0] d2_s4;
	logic [CB-1:0] px, py, pz;

	assign px = rd_s1[CB-1:0];
	assign py = rd_s1[2*CB-1:CB];
	assign pz = rd_s1[3*CB-1:2*CB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= cmd.acc_en;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2 <= (px > qx_q) ? px - qx_q : qx_q - px;
		dy_s2 <= (py > qy_q) ? py - qy_q : qy_q - py;
		dz_s2 <= (pz > qz_q) ? pz - qz_q : qz_q - pz;
		sx_s3 <= dx_s2 * dx_s2;
		sy_s3 <= dy_s2 * dy_s2;
		sz_s3 <= dz_s2 * dz_s2;
		d2_s4 <= D2B'(sx_s3) + D2B'(sy_s3) + D2B'(sz_s3);
	end

	assign sts.pipe_idle = !(cmd.acc_en || v_s2 || v_s3 || v_s4);

	// Sorted list of the smallest distances, insertion by compare and shift.
	logic [D2B-1:0] near_q [MAX_RANK];
	logic [MAX_RANK-1:0] lt;

	always_comb begin
		for (int i = 0; i < MAX_RANK; i++)
			lt[i] = d2_s4 < near_q[i];
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			for (int i = 0; i < MAX_RANK; i++)
				near_q[i] <= '1;
		end else if (v_s4) begin
			for (int i = 0; i < MAX_RANK; i++) begin
				if (lt[i]) begin
					if (i == 0)
						near_q[i] <= d2_s4;
					else if (lt[i-1])
						near_q[i] <= near_q[i-1];
					else
						near_q[i] <= d2_s4;
				end
			end
		end
	end

	// Bit-pair square root, one result bit a cycle.
	logic [D2B-1:0] rem_q;
	logic [RB-1:0] root_q;
	logic [D2B-1:0] src_q;
	logic [SQI-1:0] sq_cnt_q;
	logic [D2B+1:0] trial;
	logic [D2B+1:0] rem_sh;
	logic err_c;
	logic [KW-1:0] rank_ext;

	always_comb begin
		rank_ext = KW'(rank);
		err_c = ({1'b0, EW'(rank)} >= {1'b0, EW'(count_c)}) ||
			(32'(rank) >= MAX_RANK);
		rem_sh = {rem_q, src_q[D2B-1 -: 2]};
		trial = (D2B+2)'({root_q[D2B/2-1:0], 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_cnt_q <= '0;
		else if (cmd.sq_start)
			sq_cnt_q <= SQI'(D2B / 2);
		else if (cmd.sq_step && sq_cnt_q != '0)
			sq_cnt_q <= sq_cnt_q - 1'b1;
	end

	assign sts.sq_done = (sq_cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.sq_start) begin
			src_q <= err_c ? '0 : near_q[rank_ext[RKB-1:0] % MAX_RANK];
			rem_q <= '0;
			root_q <= '0;
		end else if (cmd.sq_step && sq_cnt_q != '0) begin
			src_q <= src_q << 2;
			if (rem_sh >= trial) begin
				rem_q <= D2B'(rem_sh - trial);
				root_q <= {root_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= D2B'(rem_sh);
				root_q <= {root_q[RB-2:0], 1'b0};
			end
		end
	end

	logic err_q;
	always_ff @(posedge clk) begin
		if (cmd.sq_start)
			err_q <= err_c;
	end

	// Scale and saturate.
	logic [PW-1:0] prod;
	logic [PW-9:0] shf;
	assign prod = PW'(root_q) * PW'(mul_factor);
	assign shf = prod[PW-1:8];

	logic full_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			full_q <= 1'b0;
		else if (cmd.mul_en)
			full_q <= 1'b1;
		else if (out_take)
			full_q <= 1'b0;
	end
	assign sts.out_full = full_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			rank_error <= err_q;
			if (err_q)
				scaled_distance <= '0;
			else if (shf > (PW-8)'({wnnd_pkg::OUT_BITS{1'b1}}))
				scaled_distance <= '1;
			else
				scaled_distance <= wnnd_pkg::OUT_BITS'(shf);
		end
	end

endmodule

/* rtl/core/wnnd_ctrl.sv */
module wnnd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_beat,
	input  logic req_type,
	output logic in_ready,
	output wnnd_pkg::wnnd_cmd_t cmd,
	input  wnnd_pkg::wnnd_sts_t sts
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_SQRT  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic rd_prev_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.acc_en = rd_prev_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					if (req_type == wnnd_pkg::REQ_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.q_start = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				if (sts.rd_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.pipe_idle) begin
					cmd.sq_start = 1'b1;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_done && !sts.out_full) begin
					cmd.sq_step = 1'b0;
					cmd.mul_en = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_prev_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_prev_q <= cmd.rd_en;
		end
	end

endmodule
